// ===== src/gstl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the glyph segment table.
package gstl_pkg;

    localparam int SEGMENTS = 16;
    localparam int SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CNT_W    = $clog2(SEGMENTS + 1);

    // Field widths fixed by the item format
    localparam int CODE_W  = 32;
    localparam int COUNT_W = 17;
    localparam int WIDTH_W = 8;
    localparam int BPP_W   = 3;
    localparam int STRIP_W = 8;
    localparam int FH_W    = 8;
    localparam int DESC_W  = 3;
    localparam int BOFF_W  = 26;
    localparam int AOFF_W  = 24;

    // Running-average divider: (mean * n + width) / (n + 1)
    localparam int DVD_W  = WIDTH_W + CNT_W + 1;
    localparam int DVS_W  = CNT_W;
    localparam int STEP_W = $clog2(DVD_W + 1);

    localparam logic [WIDTH_W-1:0] MISSING_WIDTH = WIDTH_W'(8);
    localparam logic [FH_W-1:0]    FONT_HEIGHT_RST = FH_W'(16);

    localparam logic [FH_W-1:0] DESC_TH6 = FH_W'(40);
    localparam logic [FH_W-1:0] DESC_TH3 = FH_W'(20);
    localparam logic [FH_W-1:0] DESC_TH2 = FH_W'(15);
    localparam logic [FH_W-1:0] DESC_TH1 = FH_W'(10);

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0]  low;
        logic [CODE_W-1:0]  high;
        logic [WIDTH_W-1:0] width;
        logic [BPP_W-1:0]   bpp;
        logic [STRIP_W-1:0] strip;
        logic               alpha;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [SEG_W-1:0] addr;
        t_entry           entry;
    } t_tbl_wr;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [WIDTH_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [DESC_W-1:0] descent_of(input logic [FH_W-1:0] h);
        if (h >= DESC_TH6) return DESC_W'(6);
        if (h >= DESC_TH3) return DESC_W'(3);
        if (h >= DESC_TH2) return DESC_W'(2);
        if (h >= DESC_TH1) return DESC_W'(1);
        return DESC_W'(0);
    endfunction

endpackage

// ===== src/gstl_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request items, result items, configuration.

interface gstl_in_if import gstl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
    logic [WIDTH_W-1:0] width;
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic [STRIP_W-1:0] strip;
    logic               has_alpha;

    modport source (output valid, cmd, code, count, width, bytes_per_pixel, strip,
                    has_alpha, input ready);
    modport sink   (input valid, cmd, code, count, width, bytes_per_pixel, strip,
                    has_alpha, output ready);
endinterface

interface gstl_out_if import gstl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [WIDTH_W-1:0] adv_width;
    logic [FH_W-1:0]    glyph_height;
    logic [FH_W-1:0]    ascent;
    logic [DESC_W-1:0]  descent;
    logic [STRIP_W-1:0] strip_out;
    logic [BOFF_W-1:0]  byte_offset;
    logic [AOFF_W-1:0]  alpha_offset;
    logic               alpha_valid;
    logic [WIDTH_W-1:0] peak_width;
    logic [WIDTH_W-1:0] avg_width;

    modport source (output valid, status, adv_width, glyph_height, ascent, descent,
                    strip_out, byte_offset, alpha_offset, alpha_valid, peak_width,
                    avg_width, input ready);
    modport sink   (input valid, status, adv_width, glyph_height, ascent, descent,
                    strip_out, byte_offset, alpha_offset, alpha_valid, peak_width,
                    avg_width, output ready);
endinterface

interface gstl_cfg_if import gstl_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [FH_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== src/glyph_segment_table_lookup.sv =====
`timescale 1ns / 1ps
// Top level of the glyph segment table: sequencer, offset math and result register.
//
// The block holds up to SEGMENTS disjoint glyph code ranges and serves one item at a
// time. A lookup walks the stored ranges in insertion order through the table's single
// registered read port and stops at the first hit; a hit then passes through the shared
// multiplier for the byte and alpha offsets. An insert walks the same way looking for
// an overlap; a store then runs the running average through a serial divider, one
// quotient bit a cycle.
// Input ready is high only while the sequencer is idle. Results sit in an output
// register, so the next item is taken while a finished result still waits. The
// font_height register is written through its own channel, always ready; write it only
// while the block is idle. Table contents are not cleared at reset: only the fill count
// is, and entries at or beyond it are never read as valid.
module glyph_segment_table_lookup import gstl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gstl_in_if.sink  i_in,
    gstl_cfg_if.sink i_cfg,
    gstl_out_if.source o_out
);

    // Sequencer and statistics
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [WIDTH_W-1:0] r_widest, n_widest;
    logic [WIDTH_W-1:0] r_mean, n_mean;
    logic [FH_W-1:0]    r_fh, n_fh;
    t_status            r_status, n_status;

    // Captured item
    logic               r_cmd, n_cmd;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [CODE_W-1:0]  r_hi, n_hi;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic [BPP_W-1:0]   r_bpp, n_bpp;
    logic [STRIP_W-1:0] r_strip, n_strip;
    logic               r_alpha, n_alpha;

    // Matched entry and offsets
    logic [WIDTH_W-1:0] r_hw, n_hw;
    logic [BPP_W-1:0]   r_hb, n_hb;
    logic [STRIP_W-1:0] r_hs, n_hs;
    logic               r_ha, n_ha;
    logic [BOFF_W-1:0]  r_rel, n_rel;
    logic [BOFF_W-1:0]  r_px, n_px;
    logic [BOFF_W-1:0]  r_boff, n_boff;

    // Result register
    logic               r_o_valid, n_o_valid;
    t_status            r_o_status, n_o_status;
    logic [WIDTH_W-1:0] r_o_gw, n_o_gw;
    logic [FH_W-1:0]    r_o_gh, n_o_gh;
    logic [FH_W-1:0]    r_o_asc, n_o_asc;
    logic [DESC_W-1:0]  r_o_desc, n_o_desc;
    logic [STRIP_W-1:0] r_o_strip, n_o_strip;
    logic [BOFF_W-1:0]  r_o_boff, n_o_boff;
    logic [AOFF_W-1:0]  r_o_aoff, n_o_aoff;
    logic               r_o_aval, n_o_aval;
    logic [WIDTH_W-1:0] r_o_maxw, n_o_maxw;
    logic [WIDTH_W-1:0] r_o_avew, n_o_avew;

    // Table and divider hookup
    t_tbl_wr  w_wr;
    t_entry   w_rd;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [COUNT_W-1:0]          w_n;
    logic [CODE_W:0]             w_end;
    logic [BOFF_W-1:0]           w_mul_a;
    logic [WIDTH_W-1:0]          w_mul_b;
    logic [BOFF_W+WIDTH_W-1:0]   w_mul;
    logic [CODE_W-1:0]           w_rel_full;
    logic [DESC_W-1:0]           w_desc;
    logic                        w_load_out;

    gstl_table u_table (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (r_idx[SEG_W-1:0]),
        .o_rd_data (w_rd)
    );

    gstl_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Zero count stores one glyph; the range end saturates at the top of the code space
    assign w_n   = (i_in.count == '0) ? COUNT_W'(1) : i_in.count;
    assign w_end = {1'b0, i_in.code} + (CODE_W+1)'(w_n) - (CODE_W+1)'(1);

    assign w_rel_full = r_code - w_rd.low;

    // Shared multiplier: width * rel first, then pixels * bytes per pixel
    assign w_mul_a = (r_state == S_MUL1) ? r_rel : r_px;
    assign w_mul_b = (r_state == S_MUL1) ? r_hw : WIDTH_W'(r_hb);
    assign w_mul   = (BOFF_W+WIDTH_W)'(w_mul_a) * (BOFF_W+WIDTH_W)'(w_mul_b);
    assign w_desc  = descent_of(r_fh);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_widest = r_widest;
        n_mean   = r_mean;
        n_fh     = r_fh;
        n_status = r_status;
        n_cmd    = r_cmd;
        n_code   = r_code;
        n_hi     = r_hi;
        n_width  = r_width;
        n_bpp    = r_bpp;
        n_strip  = r_strip;
        n_alpha  = r_alpha;
        n_hw     = r_hw;
        n_hb     = r_hb;
        n_hs     = r_hs;
        n_ha     = r_ha;
        n_rel    = r_rel;
        n_px     = r_px;
        n_boff   = r_boff;

        n_o_valid  = r_o_valid && !o_out.ready;
        n_o_status = r_o_status;
        n_o_gw     = r_o_gw;
        n_o_gh     = r_o_gh;
        n_o_asc    = r_o_asc;
        n_o_desc   = r_o_desc;
        n_o_strip  = r_o_strip;
        n_o_boff   = r_o_boff;
        n_o_aoff   = r_o_aoff;
        n_o_aval   = r_o_aval;
        n_o_maxw   = r_o_maxw;
        n_o_avew   = r_o_avew;

        w_wr.we          = 1'b0;
        w_wr.addr        = r_cnt[SEG_W-1:0];
        w_wr.entry.low   = r_code;
        w_wr.entry.high  = r_hi;
        w_wr.entry.width = r_width;
        w_wr.entry.bpp   = r_bpp;
        w_wr.entry.strip = r_strip;
        w_wr.entry.alpha = r_alpha;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = DVD_W'(r_mean) * DVD_W'(r_cnt) + DVD_W'(r_width);
        w_div_req.divisor  = r_cnt + CNT_W'(1);

        w_load_out = !r_o_valid || o_out.ready;

        if (i_cfg.valid) begin
            n_fh = i_cfg.data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = i_in.cmd;
                    n_code  = i_in.code;
                    n_hi    = w_end[CODE_W] ? '1 : w_end[CODE_W-1:0];
                    n_width = i_in.width;
                    n_bpp   = i_in.bytes_per_pixel;
                    n_strip = i_in.strip;
                    n_alpha = i_in.has_alpha;
                    n_idx   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_idx == r_cnt) begin
                    // Walked every stored range without a hit or an overlap
                    if (r_cmd == CMD_LOOKUP) begin
                        n_status = ST_MISS;
                        n_state  = S_OUT;
                    end else if (r_cnt == CNT_W'(SEGMENTS)) begin
                        n_status = ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        w_wr.we         = 1'b1;
                        w_div_req.start = 1'b1;
                        n_cnt           = r_cnt + CNT_W'(1);
                        if (r_width > r_widest) begin
                            n_widest = r_width;
                        end
                        n_status = ST_OK;
                        n_state  = S_DIV;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_cmd == CMD_LOOKUP) begin
                    if (r_code >= w_rd.low && r_code <= w_rd.high) begin
                        n_hw     = w_rd.width;
                        n_hb     = w_rd.bpp;
                        n_hs     = w_rd.strip;
                        n_ha     = w_rd.alpha;
                        n_rel    = w_rel_full[BOFF_W-1:0];
                        n_status = ST_OK;
                        n_state  = S_MUL1;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_RD;
                    end
                end else begin
                    if (r_code <= w_rd.high && w_rd.low <= r_hi) begin
                        n_status = ST_OVERLAP;
                        n_state  = S_OUT;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_MUL1: begin
                n_px    = w_mul[BOFF_W-1:0];
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_boff  = w_mul[BOFF_W-1:0];
                n_state = S_OUT;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_mean  = w_div_rsp.quotient;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load_out) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_maxw   = r_widest;
                    n_o_avew   = r_mean;
                    n_o_gw     = '0;
                    n_o_gh     = '0;
                    n_o_asc    = '0;
                    n_o_desc   = '0;
                    n_o_strip  = '0;
                    n_o_boff   = '0;
                    n_o_aoff   = '0;
                    n_o_aval   = 1'b0;
                    if (r_cmd == CMD_LOOKUP) begin
                        n_o_gh   = r_fh;
                        n_o_desc = w_desc;
                        n_o_asc  = r_fh - FH_W'(w_desc);
                        if (r_status == ST_OK) begin
                            n_o_gw    = r_hw;
                            n_o_strip = r_hs;
                            n_o_boff  = r_boff;
                            n_o_aval  = r_ha;
                            n_o_aoff  = r_ha ? r_px[AOFF_W-1:0] : '0;
                        end else begin
                            n_o_gw = MISSING_WIDTH;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_widest  <= '0;
            r_mean    <= '0;
            r_fh      <= FONT_HEIGHT_RST;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_widest  <= n_widest;
            r_mean    <= n_mean;
            r_fh      <= n_fh;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_cmd      <= n_cmd;
        r_code     <= n_code;
        r_hi       <= n_hi;
        r_width    <= n_width;
        r_bpp      <= n_bpp;
        r_strip    <= n_strip;
        r_alpha    <= n_alpha;
        r_hw       <= n_hw;
        r_hb       <= n_hb;
        r_hs       <= n_hs;
        r_ha       <= n_ha;
        r_rel      <= n_rel;
        r_px       <= n_px;
        r_boff     <= n_boff;
        r_o_status <= n_o_status;
        r_o_gw     <= n_o_gw;
        r_o_gh     <= n_o_gh;
        r_o_asc    <= n_o_asc;
        r_o_desc   <= n_o_desc;
        r_o_strip  <= n_o_strip;
        r_o_boff   <= n_o_boff;
        r_o_aoff   <= n_o_aoff;
        r_o_aval   <= n_o_aval;
        r_o_maxw   <= n_o_maxw;
        r_o_avew   <= n_o_avew;
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_o_status;
    assign o_out.adv_width    = r_o_gw;
    assign o_out.glyph_height = r_o_gh;
    assign o_out.ascent       = r_o_asc;
    assign o_out.descent      = r_o_desc;
    assign o_out.strip_out    = r_o_strip;
    assign o_out.byte_offset  = r_o_boff;
    assign o_out.alpha_offset = r_o_aoff;
    assign o_out.alpha_valid  = r_o_aval;
    assign o_out.peak_width   = r_o_maxw;
    assign o_out.avg_width    = r_o_avew;

endmodule

// ===== src/gstl_table.sv =====
`timescale 1ns / 1ps
// Range table storage: one write port, one registered read port.
module gstl_table import gstl_pkg::*; (
    input  logic             i_clk,
    input  t_tbl_wr          i_wr,
    input  logic [SEG_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [SEGMENTS];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// ===== src/gstl_divider.sv =====
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
module gstl_divider import gstl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0] w_shift;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DVD_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[WIDTH_W-1:0];

endmodule
